// File: design/sdmq_pkg.sv
// ----------------------------------------------------------------------------
// sdmq_pkg
// Shared types and constants for the sorted document-number match queue:
// request and status codes, controller states and the per-cell command.
// ----------------------------------------------------------------------------
package sdmq_pkg;

    localparam int DOCNO_W = 31;
    localparam int ARG_W   = 5;
    localparam int POS_W   = 5;
    localparam int CARD_W  = 6;
    localparam int OCNT_W  = 6;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_SHIFT  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_SMALLER = 2'd2,
        ST_BAD_POS = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE   = 1'b0,
        S_REPORT = 1'b1
    } t_state;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic               upd;
        t_req               op;
        logic [DOCNO_W-1:0] docno;
        logic [ARG_W-1:0]   new_arg;
        logic [POS_W-1:0]   pos;
    } t_cell_cmd;

endpackage

// File: design/sdmq_cell.sv
// ----------------------------------------------------------------------------
// sdmq_cell
// One slot of the sorted chain. Holds a (docno, arg) entry, compares it with
// the request number and takes its own, its left or its right neighbor's
// entry, or the new entry, when the chain updates.
// ----------------------------------------------------------------------------
module sdmq_cell
    import sdmq_pkg::*;
#(
    parameter int CELL_INDEX = 0
) (
    input  logic               i_clk,
    input  t_cell_cmd          i_cmd,
    input  logic               i_valid,
    input  logic [DOCNO_W-1:0] i_head_docno,
    input  logic [DOCNO_W-1:0] i_left_docno,
    input  logic [ARG_W-1:0]   i_left_arg,
    input  logic               i_left_le,
    input  logic [DOCNO_W-1:0] i_right_docno,
    input  logic [ARG_W-1:0]   i_right_arg,
    input  logic               i_right_lt,
    output logic [DOCNO_W-1:0] o_docno,
    output logic [ARG_W-1:0]   o_arg,
    output logic               o_le,
    output logic               o_lt,
    output logic               o_smaller,
    output logic [ARG_W-1:0]   o_pos_arg,
    output logic               o_eq_head
);

    localparam logic [7:0] IDX = 8'(CELL_INDEX);

    logic [DOCNO_W-1:0] r_docno, n_docno;
    logic [ARG_W-1:0]   r_arg, n_arg;
    logic               w_is_pos;
    logic               w_ge_pos;

    assign w_is_pos  = (IDX == {3'b000, i_cmd.pos});
    assign w_ge_pos  = (IDX >= {3'b000, i_cmd.pos});
    assign o_le      = i_valid && (r_docno <= i_cmd.docno);
    assign o_lt      = i_valid && (r_docno < i_cmd.docno);
    assign o_smaller = w_is_pos && i_valid && !o_le;
    assign o_pos_arg = w_is_pos ? r_arg : '0;
    assign o_eq_head = i_valid && (r_docno == i_head_docno);
    assign o_docno   = r_docno;
    assign o_arg     = r_arg;

    always_comb begin
        n_docno = r_docno;
        n_arg   = r_arg;
        if (i_cmd.upd) begin
            case (i_cmd.op)
                REQ_INSERT: begin
                    // Entries at or below the new number stay; the first
                    // larger slot takes the new entry, the rest move right.
                    if (!o_le) begin
                        if (i_left_le) begin
                            n_docno = i_cmd.docno;
                            n_arg   = i_cmd.new_arg;
                        end else begin
                            n_docno = i_left_docno;
                            n_arg   = i_left_arg;
                        end
                    end
                end
                REQ_REMOVE: begin
                    if (w_ge_pos) begin
                        n_docno = i_right_docno;
                        n_arg   = i_right_arg;
                    end
                end
                REQ_SHIFT: begin
                    // Smaller entries behind the raised one move left; the
                    // last of them hands its slot to the raised entry.
                    if (w_ge_pos) begin
                        if (i_right_lt) begin
                            n_docno = i_right_docno;
                            n_arg   = i_right_arg;
                        end else if (w_is_pos || o_lt) begin
                            n_docno = i_cmd.docno;
                            n_arg   = i_cmd.new_arg;
                        end
                    end
                end
                default: begin
                    n_docno = r_docno;
                    n_arg   = r_arg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_docno <= n_docno;
        r_arg   <= n_arg;
    end

endmodule

// File: design/sorted_docno_match_queue.sv
// ----------------------------------------------------------------------------
// sorted_docno_match_queue
// Sorted queue of (document number, source index) entries built as a chain
// of compare-and-shift cells, with head, bound, tie and fill reporting.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the slave stream (i_s_*): tuser carries the request
//   kind (clear, insert, remove at position, shift at position) and tdata
//   the number, source index and position. Every request transaction yields
//   exactly one result transaction on the master stream (o_m_*), carrying
//   the head entry, the bound entry at position cardinality-1, the tie
//   count, the fill and the enough flag in tdata and the status in tuser.
//   The cardinality register is written through the cfg channel, which is
//   always ready; write it only while no request is in flight.
//   Operation: a request is taken in the idle cycle, where the whole chain
//   compares and shifts in parallel; the next cycle computes the report
//   from the updated chain into the output register, which drives the
//   result onto the master stream. A stalled receiver holds the report
//   cycle until the output register frees, while a new request may
//   already be taken as soon as the previous report is loaded.
//   Reset empties the queue, sets cardinality to 1 and drops o_m_tvalid.
//   Entry contents are not cleared; only positions below the fill are read.
// ----------------------------------------------------------------------------
module sorted_docno_match_queue
    import sdmq_pkg::*;
#(
    parameter int MAX_ENTRIES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata from bit 0: docno[31], arg_index[5], position[5], zero pad[7].
    input  logic [47:0] i_s_tdata,
    // tuser: req_type[2].
    input  logic [1:0]  i_s_tuser,
    // Result stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata from bit 0: head_docno[31], head_arg[5], bound_docno[31],
    // tie_count[6], fill[6], enough[1].
    output logic [79:0] o_m_tdata,
    // tuser: status[2].
    output logic [1:0]  o_m_tuser,
    // Cardinality register write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [5:0]  i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    // Request fields.
    t_req               w_req;
    logic [DOCNO_W-1:0] w_dn;
    logic [ARG_W-1:0]   w_arg_in;
    logic [POS_W-1:0]   w_pos;
    logic               w_accept;

    assign w_req    = t_req'(i_s_tuser);
    assign w_dn     = i_s_tdata[30:0];
    assign w_arg_in = i_s_tdata[35:31];
    assign w_pos    = i_s_tdata[40:36];

    // Control state.
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CARD_W-1:0]  r_card;
    t_status            r_status, n_status;

    // Output register.
    logic               r_m_tvalid, n_m_tvalid;
    logic [79:0]        r_m_tdata, n_m_tdata;
    logic [1:0]         r_m_tuser, n_m_tuser;

    // Chain wiring.
    t_cell_cmd          w_cmd;
    logic [DOCNO_W-1:0] w_docno   [MAX_ENTRIES];
    logic [ARG_W-1:0]   w_arg     [MAX_ENTRIES];
    logic [ARG_W-1:0]   w_pos_arg [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] w_valid, w_le, w_lt, w_smaller, w_eq;

    logic [ARG_W-1:0]   w_sel_arg;
    logic               w_is_smaller;
    logic               w_pos_bad;
    logic               w_full;

    // Report values.
    logic [7:0]         w_card_eff;
    logic [7:0]         w_bound_idx;
    logic [DOCNO_W-1:0] w_bound;
    logic [CNT_W-1:0]   w_ties;
    logic               w_enough;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign o_m_tvalid  = r_m_tvalid;
    assign o_m_tdata   = r_m_tdata;
    assign o_m_tuser   = r_m_tuser;

    // Occupancy of each cell follows from the fill.
    always_comb begin
        for (int k = 0; k < MAX_ENTRIES; k++) begin
            w_valid[k] = (8'(k) < 8'(r_count));
        end
    end

    // Entry selected by the request position, gathered from the cells.
    always_comb begin
        w_sel_arg = '0;
        for (int k = 0; k < MAX_ENTRIES; k++) begin
            w_sel_arg = w_sel_arg | w_pos_arg[k];
        end
    end

    assign w_is_smaller = |w_smaller;
    assign w_pos_bad    = ({3'b000, w_pos} >= 8'(r_count));
    assign w_full       = (r_count == CNT_W'(MAX_ENTRIES));

    // Status of the request against the current contents.
    always_comb begin
        case (w_req)
            REQ_CLEAR:  n_status = ST_OK;
            REQ_INSERT: n_status = w_full ? ST_FULL : ST_OK;
            REQ_REMOVE: n_status = w_pos_bad ? ST_BAD_POS : ST_OK;
            REQ_SHIFT: begin
                if (w_pos_bad) begin
                    n_status = ST_BAD_POS;
                end else if (w_is_smaller) begin
                    n_status = ST_SMALLER;
                end else begin
                    n_status = ST_OK;
                end
            end
            default:    n_status = ST_OK;
        endcase
    end

    // Broadcast command; a rejected request leaves the chain untouched.
    always_comb begin
        w_cmd.upd     = w_accept && (n_status == ST_OK) && (w_req != REQ_CLEAR);
        w_cmd.op      = w_req;
        w_cmd.docno   = w_dn;
        w_cmd.new_arg = (w_req == REQ_SHIFT) ? w_sel_arg : w_arg_in;
        w_cmd.pos     = w_pos;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
            logic [DOCNO_W-1:0] w_l_docno, w_r_docno;
            logic [ARG_W-1:0]   w_l_arg, w_r_arg;
            logic               w_l_le, w_r_lt;

            if (g == 0) begin : g_first
                assign w_l_docno = '0;
                assign w_l_arg   = '0;
                assign w_l_le    = 1'b1;
            end else begin : g_mid_l
                assign w_l_docno = w_docno[g-1];
                assign w_l_arg   = w_arg[g-1];
                assign w_l_le    = w_le[g-1];
            end

            if (g == MAX_ENTRIES - 1) begin : g_last
                assign w_r_docno = '0;
                assign w_r_arg   = '0;
                assign w_r_lt    = 1'b0;
            end else begin : g_mid_r
                assign w_r_docno = w_docno[g+1];
                assign w_r_arg   = w_arg[g+1];
                assign w_r_lt    = w_lt[g+1];
            end

            sdmq_cell #(
                .CELL_INDEX (g)
            ) u_cell (
                .i_clk         (i_clk),
                .i_cmd         (w_cmd),
                .i_valid       (w_valid[g]),
                .i_head_docno  (w_docno[0]),
                .i_left_docno  (w_l_docno),
                .i_left_arg    (w_l_arg),
                .i_left_le     (w_l_le),
                .i_right_docno (w_r_docno),
                .i_right_arg   (w_r_arg),
                .i_right_lt    (w_r_lt),
                .o_docno       (w_docno[g]),
                .o_arg         (w_arg[g]),
                .o_le          (w_le[g]),
                .o_lt          (w_lt[g]),
                .o_smaller     (w_smaller[g]),
                .o_pos_arg     (w_pos_arg[g]),
                .o_eq_head     (w_eq[g])
            );
        end
    endgenerate

    // Tie count: the entries equal to the head form a run from position 0,
    // so the cell that ends the run gives the count directly.
    always_comb begin
        w_ties = '0;
        for (int k = 0; k < MAX_ENTRIES; k++) begin
            if (w_eq[k] && ((k == MAX_ENTRIES - 1) || !w_eq[(k + 1) % MAX_ENTRIES])) begin
                w_ties = w_ties | CNT_W'(k + 1);
            end
        end
    end

    // Bound entry at position cardinality-1; a zero cardinality counts as 1.
    assign w_card_eff  = (r_card == '0) ? 8'd1 : {2'b00, r_card};
    assign w_bound_idx = w_card_eff - 8'd1;
    assign w_enough    = (8'(r_count) >= w_card_eff);

    always_comb begin
        w_bound = '0;
        for (int k = 0; k < MAX_ENTRIES; k++) begin
            if (8'(k) == w_bound_idx) begin
                w_bound = w_docno[k];
            end
        end
        if (!w_enough) begin
            w_bound = '0;
        end
    end

    function automatic logic [OCNT_W-1:0] sat_cnt(input logic [7:0] v);
        logic [OCNT_W-1:0] res;
        res = (v > 8'd63) ? 6'd63 : v[OCNT_W-1:0];
        return res;
    endfunction

    // Controller: take a request, then load its report.
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_m_tvalid = r_m_tvalid;
        n_m_tdata  = r_m_tdata;
        n_m_tuser  = r_m_tuser;

        if (r_m_tvalid && i_m_tready) begin
            n_m_tvalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_REPORT;
                    if (w_req == REQ_CLEAR) begin
                        n_count = '0;
                    end else if (n_status == ST_OK && w_req == REQ_INSERT) begin
                        n_count = r_count + CNT_W'(1);
                    end else if (n_status == ST_OK && w_req == REQ_REMOVE) begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
            end
            S_REPORT: begin
                if (!r_m_tvalid || i_m_tready) begin
                    n_state    = S_IDLE;
                    n_m_tvalid = 1'b1;
                    n_m_tdata  = {w_enough,
                                  sat_cnt(8'(r_count)),
                                  sat_cnt(8'(w_ties)),
                                  w_bound,
                                  w_valid[0] ? w_arg[0] : {ARG_W{1'b0}},
                                  w_valid[0] ? w_docno[0] : {DOCNO_W{1'b0}}};
                    n_m_tuser  = r_status;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_card     <= CARD_W'(1);
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_m_tvalid <= n_m_tvalid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_card <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
        end
        r_m_tdata <= n_m_tdata;
        r_m_tuser <= n_m_tuser;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // The fill never exceeds the chain length.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        8'(r_count) <= 8'(MAX_ENTRIES))
        else $error("fill exceeds queue depth");

    // A clear empties the queue in the next cycle.
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_req == REQ_CLEAR) |=> (r_count == '0))
        else $error("clear did not empty the queue");

    // A rejected request leaves the fill unchanged.
    a_reject_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && n_status != ST_OK) |=> $stable(r_count))
        else $error("rejected request changed the fill");

    // When a report is due and the output is free, the result is loaded and the controller returns to idle.
    a_load_on_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REPORT && (!r_m_tvalid || i_m_tready))
            |=> (r_m_tvalid && r_state == S_IDLE))
        else $error("report not loaded into output register");

endmodule

// File: test/sorted_docno_match_queue_test.sv
// ----------------------------------------------------------------------------
// sorted_docno_match_queue_test
// Self-checking testbench for the sorted document-number match queue. A
// table of directed requests is followed by random request sequences under
// several cardinality settings. Every result transaction is checked field by
// field against a behavioral queue model in this file or a typed table row.
// ----------------------------------------------------------------------------
module sorted_docno_match_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sdmq_pkg::*;

    localparam int MAX_ENTRIES    = 32;
    localparam int PHASE_ITEMS    = 225;
    localparam int NUM_PHASES     = 8;
    localparam int DIR_ROWS       = 22;
    localparam int LONG_HOLD      = 400;
    localparam int HOLD_AFTER     = 600;
    localparam int WATCHDOG_LIMIT = 5000;

    // One result transaction, split into its fields.
    typedef struct packed {
        logic [DOCNO_W-1:0] head_docno;
        logic [ARG_W-1:0]   head_arg;
        logic [DOCNO_W-1:0] bound_docno;
        logic [OCNT_W-1:0]  tie_count;
        logic [OCNT_W-1:0]  fill;
        logic               enough;
        t_status            status;
    } report_t;

    // One row of the directed table. A row is sent reps times in a row; when
    // typed is set, want is the literal result instead of the model's.
    typedef struct {
        t_req               op;
        logic [DOCNO_W-1:0] docno;
        logic [ARG_W-1:0]   arg;
        logic [POS_W-1:0]   pos;
        int                 reps;
        bit                 typed;
        report_t            want;
    } dir_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [47:0] i_s_tdata;
    logic [1:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [79:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [5:0]  i_cfg_data;

    // Model of the queue: sorted entries, fill and the cardinality register.
    logic [DOCNO_W-1:0] q_docno [MAX_ENTRIES];
    logic [ARG_W-1:0]   q_arg [MAX_ENTRIES];
    int                 q_count = 0;
    logic [CARD_W-1:0]  card_reg = CARD_W'(1);

    // Results still owed by the block, oldest first.
    report_t report_due [$];

    // Travel with each request so that the acceptance monitor knows whether a
    // literal result was typed into the table for it.
    logic    row_typed;
    report_t row_want;

    int mismatch_count = 0;
    int reports_taken  = 0;
    int stall_cycles   = 0;

    // Stimulus-side view of the queue: only the fill and an upper bound of
    // every number held, enough to aim positions and shifts at valid cases.
    int                 drv_fill = 0;
    logic [DOCNO_W-1:0] drv_top = '0;
    bit                 sender_gaps = 1'b1;

    dir_row_t dir_table [DIR_ROWS];

    sorted_docno_match_queue #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            q_docno[i] = '0;
            q_arg[i]   = '0;
        end
    end

    // Applies one request to the queue model and returns the report that the
    // block must give for it. Failed requests leave the model untouched.
    function automatic report_t apply_request(t_req op, logic [DOCNO_W-1:0] dn,
                                              logic [ARG_W-1:0] arg,
                                              logic [POS_W-1:0] pos);
        report_t          r;
        t_status          st;
        int               i;
        int               k;
        int               eff_card;
        logic [ARG_W-1:0] moved_arg;
        st = ST_OK;
        case (op)
            REQ_CLEAR: begin
                q_count = 0;
            end
            REQ_INSERT: begin
                if (q_count >= MAX_ENTRIES) begin
                    st = ST_FULL;
                end else begin
                    // A new entry goes behind every entry with an equal number.
                    i = 0;
                    while (i < q_count && q_docno[i] <= dn) i++;
                    for (k = q_count; k > i; k--) begin
                        q_docno[k] = q_docno[k-1];
                        q_arg[k]   = q_arg[k-1];
                    end
                    q_docno[i] = dn;
                    q_arg[i]   = arg;
                    q_count++;
                end
            end
            REQ_REMOVE: begin
                if (int'(pos) >= q_count) begin
                    st = ST_BAD_POS;
                end else begin
                    for (k = int'(pos); k + 1 < q_count; k++) begin
                        q_docno[k] = q_docno[k+1];
                        q_arg[k]   = q_arg[k+1];
                    end
                    q_count--;
                end
            end
            default: begin
                if (int'(pos) >= q_count) begin
                    st = ST_BAD_POS;
                end else if (dn < q_docno[pos]) begin
                    st = ST_SMALLER;
                end else begin
                    // The raised entry slides up past strictly smaller numbers
                    // only, so it lands ahead of any equal ones.
                    moved_arg = q_arg[pos];
                    k = int'(pos);
                    while (k + 1 < q_count && q_docno[k+1] < dn) begin
                        q_docno[k] = q_docno[k+1];
                        q_arg[k]   = q_arg[k+1];
                        k++;
                    end
                    q_docno[k] = dn;
                    q_arg[k]   = moved_arg;
                end
            end
        endcase

        // A cardinality of zero counts as one.
        eff_card = (card_reg == '0) ? 1 : int'(card_reg);
        r = '0;
        r.status = st;
        r.fill   = OCNT_W'(q_count);
        r.enough = (q_count >= eff_card);
        if (q_count > 0) begin
            r.head_docno = q_docno[0];
            r.head_arg   = q_arg[0];
            i = 0;
            while (i < q_count && q_docno[i] == q_docno[0]) i++;
            r.tie_count = OCNT_W'(i);
        end
        if (eff_card <= q_count) r.bound_docno = q_docno[eff_card-1];
        return r;
    endfunction

    function automatic report_t report_of(logic [DOCNO_W-1:0] head, logic [ARG_W-1:0] harg,
                                          logic [DOCNO_W-1:0] bound, logic [OCNT_W-1:0] ties,
                                          logic [OCNT_W-1:0] fill, logic enough, t_status st);
        report_t r;
        r.head_docno  = head;
        r.head_arg    = harg;
        r.bound_docno = bound;
        r.tie_count   = ties;
        r.fill        = fill;
        r.enough      = enough;
        r.status      = st;
        return r;
    endfunction

    // Idle stretch for either side: mostly none or short, now and then long.
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t ns: %s mismatch, expected %0d (0x%h), got %0d (0x%h)",
                     $time, name, want, want, got, got);
        end
    endtask

    task automatic check_report(report_t want);
        compare_field("head_docno",  want.head_docno,  o_m_tdata[30:0]);
        compare_field("head_arg",    want.head_arg,    o_m_tdata[35:31]);
        compare_field("bound_docno", want.bound_docno, o_m_tdata[66:36]);
        compare_field("tie_count",   want.tie_count,   o_m_tdata[72:67]);
        compare_field("fill",        want.fill,        o_m_tdata[78:73]);
        compare_field("enough",      want.enough,      o_m_tdata[79]);
        compare_field("status",      want.status,      o_m_tuser);
    endtask

    // Offers one request and returns at the edge where it is accepted. The
    // valid line is left high, so a request that follows without a gap keeps it high.
    task automatic send_item(t_req op, logic [DOCNO_W-1:0] dn, logic [ARG_W-1:0] arg,
                             logic [POS_W-1:0] pos, bit typed, report_t want);
        int gap;
        gap = sender_gaps ? idle_len() : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {7'b0, pos, arg, dn};
        row_typed  <= typed;
        row_want   <= want;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);

        case (op)
            REQ_CLEAR: begin
                drv_fill = 0;
                drv_top  = '0;
            end
            REQ_INSERT: begin
                if (drv_fill < MAX_ENTRIES) drv_fill++;
                if (dn > drv_top) drv_top = dn;
            end
            REQ_REMOVE: begin
                if (int'(pos) < drv_fill) drv_fill--;
            end
            default: begin
                if (dn > drv_top) drv_top = dn;
            end
        endcase
    endtask

    // Returns once every owed result has come back. The first edge is always
    // waited out so that a request taken at this very edge is already queued.
    task automatic wait_drained();
        do @(posedge i_clk); while (report_due.size() != 0);
    endtask

    // Register writes happen only with the queue idle, after a short pause.
    task automatic write_cardinality(logic [CARD_W-1:0] value);
        wait_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Acceptance monitor, result checker and watchdog. Everything here is
    // sampled at the rising edge, before the block or the drivers update.
    always @(posedge i_clk) begin : monitor
        report_t got;
        logic    moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                card_reg = i_cfg_data;
                moved = 1'b1;
            end
            if (i_s_tvalid && o_s_tready) begin
                // The model always advances, even when the table row carries
                // its own literal result.
                got = apply_request(t_req'(i_s_tuser), i_s_tdata[30:0],
                                    i_s_tdata[35:31], i_s_tdata[40:36]);
                report_due.push_back(row_typed ? row_want : got);
                moved = 1'b1;
            end
            if (o_m_tvalid && i_m_tready) begin
                reports_taken++;
                moved = 1'b1;
                if (report_due.size() == 0) begin
                    mismatch_count++;
                    $display("%0t ns: result transaction with none expected, tdata 0x%h tuser %0d",
                             $time, o_m_tdata, o_m_tuser);
                end else begin
                    check_report(report_due.pop_front());
                end
            end
            if (moved) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t ns: no transaction for %0d cycles, %0d results owed",
                         $time, WATCHDOG_LIMIT, report_due.size());
                $display("** sorted_docno_match_queue: FAILED **");
                $finish;
            end
        end
    end

    // Result receiver. Ready runs high in bursts of random length with random
    // gaps; once, after enough results, it holds off for a long stretch so the
    // block backs up and stops taking requests while the sender keeps offering.
    initial begin : receiver
        int  hold;
        int  run;
        bit  held_long;
        held_long = 1'b0;
        i_m_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            hold = idle_len();
            if (!held_long && reports_taken >= HOLD_AFTER) begin
                hold = LONG_HOLD;
                held_long = 1'b1;
            end
            if (hold > 0) begin
                i_m_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 24);
            repeat (run) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        logic [CARD_W-1:0]  phase_cards [NUM_PHASES];
        int                 ph;
        int                 sent;
        int                 n;
        int                 len;
        int                 kind;
        int                 roll;
        bit                 narrow;
        t_req               op;
        logic [DOCNO_W-1:0] dn;
        logic [DOCNO_W-1:0] base;
        logic [ARG_W-1:0]   arg;
        logic [POS_W-1:0]   pos;
        logic [31:0]        up;

        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= REQ_CLEAR;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        row_typed   <= 1'b0;
        row_want    <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, run with the cardinality left at its reset value of
        // one. Typed rows are the cases whose result is plain from the spec:
        // the empty queue, the extremes and the error statuses.
        dir_table = '{
            // Clear on an empty queue, with every unused field at all ones.
            '{REQ_CLEAR, 31'h7FFF_FFFF, 5'd31, 5'd31, 1, 1'b1,
              report_of('0, '0, '0, '0, '0, 1'b0, ST_OK)},
            // Remove and shift on an empty queue hit a bad position.
            '{REQ_REMOVE, 31'h0, 5'd0, 5'd0, 1, 1'b1,
              report_of('0, '0, '0, '0, '0, 1'b0, ST_BAD_POS)},
            '{REQ_SHIFT, 31'h7FFF_FFFF, 5'd31, 5'd31, 1, 1'b1,
              report_of('0, '0, '0, '0, '0, 1'b0, ST_BAD_POS)},
            // Largest number, then zero, which sorts ahead of it.
            '{REQ_INSERT, 31'h7FFF_FFFF, 5'd31, 5'd31, 1, 1'b1,
              report_of(31'h7FFF_FFFF, 5'd31, 31'h7FFF_FFFF, 6'd1, 6'd1, 1'b1, ST_OK)},
            '{REQ_INSERT, 31'h0, 5'd0, 5'd0, 1, 1'b1,
              report_of('0, '0, '0, 6'd1, 6'd2, 1'b1, ST_OK)},
            // Two equal numbers: the second one lands behind the first.
            '{REQ_INSERT, 31'd1, 5'd5, 5'd0, 1, 1'b0, '0},
            '{REQ_INSERT, 31'd1, 5'd6, 5'd17, 1, 1'b0, '0},
            // Shift to the same number leaves the entry in place.
            '{REQ_SHIFT, 31'd0, 5'd9, 5'd0, 1, 1'b0, '0},
            // Shift to a smaller number is refused.
            '{REQ_SHIFT, 31'd0, 5'd0, 5'd1, 1, 1'b1,
              report_of('0, '0, '0, 6'd1, 6'd4, 1'b1, ST_SMALLER)},
            '{REQ_SHIFT, 31'd1, 5'd0, 5'd1, 1, 1'b0, '0},
            // Raised onto a run of equal numbers, the entry stays ahead of them.
            '{REQ_SHIFT, 31'd1, 5'd0, 5'd0, 1, 1'b0, '0},
            '{REQ_SHIFT, 31'd2, 5'd0, 5'd0, 1, 1'b0, '0},
            '{REQ_REMOVE, 31'h5555_5555, 5'd21, 5'd3, 1, 1'b0, '0},
            '{REQ_REMOVE, 31'h0, 5'd0, 5'd7, 1, 1'b0, '0},
            '{REQ_REMOVE, 31'h0, 5'd0, 5'd0, 1, 1'b0, '0},
            '{REQ_CLEAR, 31'h2AAA_AAAA, 5'd10, 5'd10, 1, 1'b1,
              report_of('0, '0, '0, '0, '0, 1'b0, ST_OK)},
            // Fill the queue with one number, so the tie count reaches the top.
            '{REQ_INSERT, 31'h2AAA_AAAA, 5'd10, 5'd21, MAX_ENTRIES, 1'b0, '0},
            '{REQ_INSERT, 31'h5555_5555, 5'd21, 5'd10, 1, 1'b1,
              report_of(31'h2AAA_AAAA, 5'd10, 31'h2AAA_AAAA, 6'd32, 6'd32, 1'b1, ST_FULL)},
            '{REQ_SHIFT, 31'h5555_5555, 5'd21, 5'd31, 1, 1'b0, '0},
            '{REQ_REMOVE, 31'h0, 5'd0, 5'd31, 1, 1'b0, '0},
            '{REQ_SHIFT, 31'h7FFF_FFFF, 5'd0, 5'd0, 1, 1'b0, '0},
            '{REQ_CLEAR, 31'h1234_5678, 5'd3, 5'd12, 1, 1'b0, '0}
        };
        for (int r = 0; r < DIR_ROWS; r++) begin
            for (int k = 0; k < dir_table[r].reps; k++) begin
                send_item(dir_table[r].op, dir_table[r].docno, dir_table[r].arg,
                          dir_table[r].pos, dir_table[r].typed, dir_table[r].want);
            end
        end
        i_s_tvalid <= 1'b0;

        // Random part. Each phase runs under its own cardinality: the range
        // ends, zero (read as one), values beyond the queue size, and a few
        // in between.
        phase_cards = '{6'd32, 6'd0, 6'd63, 6'd2, 6'd1, 6'd33, 6'd17, 6'd5};
        phase_cards[NUM_PHASES-1] = CARD_W'($urandom_range(0, 63));
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            write_cardinality(phase_cards[ph]);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                // Sequence kinds: growing the queue (so it fills up), churn
                // with many shifts and removes, and unshaped noise. Narrow
                // number windows make ties frequent.
                kind   = $urandom_range(0, 99);
                len    = $urandom_range(4, 60);
                narrow = ($urandom_range(0, 1) == 1);
                base   = DOCNO_W'($urandom);
                sender_gaps = ($urandom_range(0, 3) != 0);
                if (kind < 45 && $urandom_range(0, 1) == 1) begin
                    send_item(REQ_CLEAR, DOCNO_W'($urandom), ARG_W'($urandom),
                              POS_W'($urandom), 1'b0, '0);
                    sent++;
                end
                for (n = 0; n < len && sent < PHASE_ITEMS; n++) begin
                    roll = $urandom_range(0, 99);
                    if (kind < 45) begin
                        op = (roll < 70) ? REQ_INSERT : (roll < 85) ? REQ_SHIFT :
                             (roll < 98) ? REQ_REMOVE : REQ_CLEAR;
                    end else if (kind < 85) begin
                        op = (roll < 30) ? REQ_INSERT : (roll < 65) ? REQ_SHIFT :
                             (roll < 98) ? REQ_REMOVE : REQ_CLEAR;
                    end else begin
                        op = t_req'($urandom_range(0, 3));
                    end
                    dn  = narrow ? DOCNO_W'(base + $urandom_range(0, 7)) : DOCNO_W'($urandom);
                    if ($urandom_range(0, 49) == 0) dn = '0;
                    arg = ARG_W'($urandom);
                    pos = POS_W'($urandom);
                    if (kind < 85) begin
                        // Mostly aim shifts at a number no smaller than any
                        // held, and positions inside the current fill.
                        if (op == REQ_SHIFT && $urandom_range(0, 3) != 0) begin
                            up = {1'b0, drv_top} + $urandom_range(0, 3);
                            dn = (up > 32'h7FFF_FFFF) ? 31'h7FFF_FFFF : up[30:0];
                        end
                        if ((op == REQ_SHIFT || op == REQ_REMOVE) && drv_fill > 0 &&
                            $urandom_range(0, 9) != 0) begin
                            pos = POS_W'($urandom_range(0, drv_fill - 1));
                        end
                    end
                    send_item(op, dn, arg, pos, 1'b0, '0);
                    sent++;
                end
            end
            i_s_tvalid <= 1'b0;
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("** sorted_docno_match_queue: PASSED **");
        end else begin
            $display("** sorted_docno_match_queue: FAILED **");
        end
        $finish;
    end

endmodule

// File: sim.f
design/sdmq_pkg.sv
design/sdmq_cell.sv
design/sorted_docno_match_queue.sv
test/sorted_docno_match_queue_test.sv
